// ===== rtl/ntip_pkg.sv =====
// ----------------------------------------------------------------------------
// ntip_pkg
// Shared constants and types for the table interpolator: table geometry,
// fixed-point widths and the table access request.
// ----------------------------------------------------------------------------
package ntip_pkg;

	localparam int TABLE_DEPTH = 4096;
	localparam int ROW_STRIDE  = 6;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	localparam int VAL_W  = 32;               // Q16.16 value
	localparam int FAC_W  = 16;               // Q4.12 factor
	localparam int FRAC_W = 12;

	// multiplier operand and floored result widths
	localparam int MA_W     = 48;
	localparam int MUL_LO_W = MA_W / 2;
	localparam int PROD_W   = MUL_LO_W + 1 + FAC_W;
	localparam int FULL_W   = MA_W + FAC_W;
	localparam int MR_W     = FULL_W - FRAC_W;
	localparam int SUM_W    = MR_W + 1;

	// index sums: base + 2*ROW_STRIDE + 2*stride
	localparam int IDX_W = 18;

	localparam logic [1:0] MODE_WRITE = 2'd0;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} tbl_req_t;

endpackage

// ===== rtl/newton_table_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// newton_table_interpolator_top
// Quadratic forward-difference interpolation over a stored property table,
// one or two dimensions, on one table and one shared multiply unit.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  command  | start, busy          | mode, table_address, table_word, base_index,
//           |                      | column_stride, factors, scales
//  result   | done (one-cycle)     | result_value, address_error, saturated
//
// A command transfers at a clock edge with start high and busy low.
// Table writes and rejected queries never leave idle, so busy stays low.
// Each row of a query needs three table reads and six passes of the multiply
// unit, which sets the query time; a two-dimensional query reads three rows.
// The result strobe cannot be held off. Table contents are undefined after reset.
// ----------------------------------------------------------------------------
module newton_table_interpolator_top
	import ntip_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [11:0]             table_address,
	input  logic signed [31:0]      table_word,
	input  logic [11:0]             base_index,
	input  logic [9:0]              column_stride,
	input  logic signed [FAC_W-1:0] x_first_factor,
	input  logic signed [FAC_W-1:0] x_second_factor,
	input  logic signed [FAC_W-1:0] y_first_factor,
	input  logic signed [FAC_W-1:0] y_second_factor,
	input  logic signed [FAC_W-1:0] inner_scale,
	input  logic signed [FAC_W-1:0] outer_scale,
	output logic                    done,
	output logic signed [31:0]      result_value,
	output logic                    address_error,
	output logic                    saturated
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_MUL  = 5'b00100,
		S_SUM  = 5'b01000,
		S_COMB = 5'b10000
	} state_t;

	typedef enum logic [5:0] {
		ST_D0F = 6'b000001,     // (m-a)*first
		ST_D0S = 6'b000010,     // *scale -> d0
		ST_D1F = 6'b000100,     // (c-m)*first
		ST_D1S = 6'b001000,     // *scale -> d1
		ST_TF  = 6'b010000,     // (d1-d0)*second
		ST_TS  = 6'b100000      // *scale -> curvature
	} step_t;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	state_t                  state_q;
	step_t                   step_q;
	logic [1:0]              cnt_q;
	logic [1:0]              row_q;
	logic                    two_d_q;
	logic                    comb_q;
	logic                    sat_q;
	logic [IDX_W-1:0]        row_base_q;
	logic [9:0]              stride_q;
	logic signed [FAC_W-1:0] xf_q, xs_q, yf_q, ys_q, pi_q, pe_q;
	logic signed [VAL_W-1:0] a_q, m_q, c_q;
	logic signed [MA_W-1:0]  d0_q;
	logic signed [VAL_W-1:0] rowv_q [3];

	logic                    done_q;
	logic signed [VAL_W-1:0] result_q;
	logic                    err_q;
	logic                    satout_q;

	tbl_req_t                req;
	logic [VAL_W-1:0]        rd_data;
	logic [IDX_W-1:0]        rd_idx;
	logic [IDX_W-1:0]        chk_idx;
	logic                    accept;
	logic                    write_err;
	logic                    read_err;

	logic                    mul_start;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [FAC_W-1:0] mul_f;
	logic                    mul_done;
	logic signed [MR_W-1:0]  mul_res;
	logic signed [MA_W-1:0]  mul_res_a;

	logic signed [FAC_W-1:0] first_sel, second_sel, scale_sel;
	logic signed [SUM_W-1:0] sum_w;
	logic                    row_sat;
	logic signed [VAL_W-1:0] row_val;

	assign accept    = start && (state_q == S_IDLE);
	assign write_err = 32'(table_address) >= TABLE_DEPTH;

	// last point of the last row is the largest index a query touches
	assign chk_idx = IDX_W'(base_index) + (mode[1] ? IDX_W'(2 * ROW_STRIDE) : '0)
	               + IDX_W'({column_stride, 1'b0});
	assign read_err = 32'(chk_idx) >= TABLE_DEPTH;

	always_comb begin
		case (cnt_q)
			2'd0:    rd_idx = row_base_q;
			2'd1:    rd_idx = row_base_q + IDX_W'(stride_q);
			default: rd_idx = row_base_q + IDX_W'({stride_q, 1'b0});
		endcase
		req.we    = accept && (mode == MODE_WRITE) && !write_err;
		req.waddr = ADDR_W'(table_address);
		req.wdata = table_word;
		req.raddr = rd_idx[ADDR_W-1:0];
	end

	ntip_table u_table (
		.clk     (clk),
		.req     (req),
		.rd_data (rd_data)
	);

	assign first_sel  = comb_q ? yf_q : xf_q;
	assign second_sel = comb_q ? ys_q : xs_q;
	assign scale_sel  = comb_q ? pe_q : pi_q;
	assign mul_res_a  = $signed(mul_res[MA_W-1:0]);

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_f     = '0;
		case (state_q)
			S_READ: begin
				if (cnt_q == 2'd3) begin
					mul_start = 1'b1;
					mul_a     = MA_W'(m_q) - MA_W'(a_q);
					mul_f     = first_sel;
				end
			end
			S_COMB: begin
				mul_start = 1'b1;
				mul_a     = MA_W'(rowv_q[1]) - MA_W'(rowv_q[0]);
				mul_f     = yf_q;
			end
			S_MUL: begin
				if (mul_done) begin
					case (step_q)
						ST_D0F, ST_D1F, ST_TF: begin
							mul_start = 1'b1;
							mul_a     = mul_res_a;
							mul_f     = scale_sel;
						end
						ST_D0S: begin
							mul_start = 1'b1;
							mul_a     = MA_W'(c_q) - MA_W'(m_q);
							mul_f     = first_sel;
						end
						ST_D1S: begin
							mul_start = 1'b1;
							mul_a     = mul_res_a - d0_q;
							mul_f     = second_sel;
						end
						default: begin
							mul_start = 1'b0;
						end
					endcase
				end
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	ntip_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.f      (mul_f),
		.done   (mul_done),
		.res    (mul_res)
	);

	// f = a + d0 + floor(t/2), clipped to Q16.16
	always_comb begin
		sum_w   = SUM_W'(a_q) + SUM_W'(d0_q) + SUM_W'(mul_res >>> 1);
		row_sat = !((&sum_w[SUM_W-1:VAL_W-1]) || !(|sum_w[SUM_W-1:VAL_W-1]));
		if (row_sat) begin
			row_val = sum_w[SUM_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			row_val = sum_w[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (mode == MODE_WRITE || read_err) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (cnt_q == 2'd3) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mul_done && step_q == ST_TS) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (comb_q || !two_d_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (row_q == 2'd2) begin
						state_q <= S_COMB;
					end else begin
						state_q <= S_READ;
					end
				end
				S_COMB: begin
					state_q <= S_MUL;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					xf_q       <= x_first_factor;
					xs_q       <= x_second_factor;
					yf_q       <= y_first_factor;
					ys_q       <= y_second_factor;
					pi_q       <= inner_scale;
					pe_q       <= outer_scale;
					stride_q   <= column_stride;
					row_base_q <= IDX_W'(base_index);
					two_d_q    <= mode[1];
					comb_q     <= 1'b0;
					sat_q      <= 1'b0;
					row_q      <= 2'd0;
					cnt_q      <= 2'd0;
					result_q   <= '0;
					satout_q   <= 1'b0;
					err_q      <= (mode == MODE_WRITE) ? write_err : read_err;
				end
			end
			S_READ: begin
				cnt_q <= cnt_q + 2'd1;
				case (cnt_q)
					2'd1:    a_q <= $signed(rd_data);
					2'd2:    m_q <= $signed(rd_data);
					2'd3: begin
						c_q    <= $signed(rd_data);
						step_q <= ST_D0F;
					end
					default: begin
						a_q <= a_q;
					end
				endcase
			end
			S_MUL: begin
				if (mul_done) begin
					case (step_q)
						ST_D0F:  step_q <= ST_D0S;
						ST_D0S: begin
							d0_q   <= mul_res_a;
							step_q <= ST_D1F;
						end
						ST_D1F:  step_q <= ST_D1S;
						ST_D1S:  step_q <= ST_TF;
						ST_TF:   step_q <= ST_TS;
						default: step_q <= ST_TS;
					endcase
				end
			end
			S_SUM: begin
				sat_q <= sat_q | row_sat;
				if (comb_q || !two_d_q) begin
					result_q <= row_val;
					satout_q <= sat_q | row_sat;
					err_q    <= 1'b0;
				end else begin
					rowv_q[row_q] <= row_val;
					if (row_q == 2'd2) begin
						comb_q <= 1'b1;
					end else begin
						row_q      <= row_q + 2'd1;
						row_base_q <= row_base_q + IDX_W'(ROW_STRIDE);
						cnt_q      <= 2'd0;
					end
				end
			end
			S_COMB: begin
				a_q    <= rowv_q[0];
				m_q    <= rowv_q[1];
				c_q    <= rowv_q[2];
				step_q <= ST_D0F;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign result_value  = result_q;
	assign address_error = err_q;
	assign saturated     = satout_q;

endmodule

// ===== rtl/ntip_table.sv =====
// ----------------------------------------------------------------------------
// ntip_table
// Property table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ntip_table
	import ntip_pkg::*;
(
	input  logic             clk,
	input  tbl_req_t         req,
	output logic [VAL_W-1:0] rd_data
);

	logic [VAL_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_data <= mem[req.raddr];
	end

endmodule

// ===== rtl/ntip_mul.sv =====
// ----------------------------------------------------------------------------
// ntip_mul
// Shared multiply unit: res = floor(a * f / 2^12). The wide operand is
// split in two halves that pass through one narrow multiplier in turn.
// ----------------------------------------------------------------------------
module ntip_mul
	import ntip_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [MA_W-1:0]  a,
	input  logic signed [FAC_W-1:0] f,
	output logic                    done,
	output logic signed [MR_W-1:0]  res
);

	typedef enum logic [2:0] {
		M_IDLE = 3'b001,
		M_LO   = 3'b010,
		M_HI   = 3'b100
	} mul_state_t;

	mul_state_t               state_q;
	logic signed [MA_W-1:0]   a_q;
	logic signed [FAC_W-1:0]  f_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [MUL_LO_W:0] op;
	logic signed [PROD_W-1:0] prod;
	logic signed [FULL_W-1:0] full;
	logic                     done_q;
	logic signed [MR_W-1:0]   res_q;

	// low half is unsigned, high half carries the sign
	always_comb begin
		if (state_q == M_LO) begin
			op = $signed({1'b0, a_q[MUL_LO_W-1:0]});
		end else begin
			op = $signed({a_q[MA_W-1], a_q[MA_W-1:MUL_LO_W]});
		end
		prod = PROD_W'(op * f_q);
		full = FULL_W'(acc_q) + (FULL_W'(prod) <<< MUL_LO_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						state_q <= M_LO;
					end
				end
				M_LO: begin
					state_q <= M_HI;
				end
				M_HI: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			a_q <= a;
			f_q <= f;
		end
		if (state_q == M_LO) begin
			acc_q <= prod;
		end
		if (state_q == M_HI) begin
			res_q <= $signed(full[FULL_W-1:FRAC_W]);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
